### rtl/pwrdb_pkg.sv
package pwrdb_pkg;

    localparam int LOG_FRACTION_BITS = 8;

    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int REG_W  = 16;

    localparam logic [REG_W-1:0] GAIN_RESET   = 16'd2560;
    localparam logic [REG_W-1:0] OFFSET_RESET = 16'd0;

    typedef enum logic {
        CFG_GAIN   = 1'b0,
        CFG_OFFSET = 1'b1
    } t_cfg_idx;

    // result of one squaring step: fraction bit and renormalized mantissa
    typedef struct packed {
        logic              bit_out;
        logic [DATA_W-1:0] mant;
    } t_sq_step;

    function automatic logic [POS_W-1:0] lead_one(input logic [DATA_W-1:0] x);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (x[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    function automatic t_sq_step square_step(input logic [DATA_W-1:0] m);
        logic [2*DATA_W-1:0] sq;
        t_sq_step r;
        sq = {{DATA_W{1'b0}}, m} * {{DATA_W{1'b0}}, m};
        r.bit_out = sq[2*DATA_W-1];
        r.mant = sq[2*DATA_W-1] ? sq[2*DATA_W-1:DATA_W] : sq[2*DATA_W-2:DATA_W-1];
        return r;
    endfunction

endpackage

### rtl/power_ratio_to_decibels.sv
// Converts a signal/noise power pair (unsigned Q16.16 each) into
// |gain * log10(S/N) + offset| in unsigned Q8.8 dB, one item per clock while
// o_stall is low. One stage normalizes both inputs, one stage per fraction bit
// squares the mantissas (one 32x32 multiplier per operand per stage), then
// difference, log10 scale, gain multiply, offset add with magnitude, and the
// output register. A two-entry output buffer lets items keep entering while
// one result waits. Zero noise, or a magnitude above 255.996 dB, gives 0xFFFF
// with o_saturated set; a zero signal takes the -18 floor of log10. Gain
// (index 0, reset 10.0) and offset (index 1, reset 0) are signed Q8.8; the user
// must write them only while idle, and the block itself does not enforce this.
module power_ratio_to_decibels (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pwrdb_pkg::DATA_W-1:0]  i_signal_power,
    input  logic [pwrdb_pkg::DATA_W-1:0]  i_noise_power,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [15:0]                   o_decibels,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [pwrdb_pkg::REG_W-1:0]   i_cfg_data
);
    import pwrdb_pkg::*;

    localparam int F     = LOG_FRACTION_BITS;
    localparam int NS    = F + 5;
    localparam int D_W   = F + 7;
    localparam int LG_W  = F + 22;
    localparam int PR_W  = LG_W + REG_W;
    localparam int ACC_W = PR_W + 1;
    localparam int Q_W   = ACC_W + 1 - (F + 16);

    localparam logic signed [16:0]     LOG10_OF_2 = 17'sd19728;
    localparam logic signed [LG_W-1:0] LG_FLOOR   =
        LG_W'(-(64'sd18 <<< (LOG_FRACTION_BITS + 16)));
    localparam logic [ACC_W:0]         RND_HALF   =
        (ACC_W+1)'(64'd1 << (LOG_FRACTION_BITS + 15));

    // configuration
    logic signed [REG_W-1:0] r_gain;
    logic signed [REG_W-1:0] r_offset;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN:   r_gain   <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic          w_en;
    logic [NS:1]   r_v;
    logic [NS:1]   r_nz;
    logic [F+2:1]  r_sz;
    logic          r_skid_v;

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-1:1], i_valid};
        end
    end

    // payload
    logic [DATA_W-1:0] r_m_s [0:F];
    logic [DATA_W-1:0] r_m_n [0:F];
    logic [POS_W-1:0]  r_p_s [0:F];
    logic [POS_W-1:0]  r_p_n [0:F];
    logic [F-1:0]      r_f_s [0:F];
    logic [F-1:0]      r_f_n [0:F];
    t_sq_step          w_sq_s [1:F];
    t_sq_step          w_sq_n [1:F];

    logic [POS_W-1:0]         w_p_s, w_p_n;
    logic signed [D_W-1:0]    w_d, r_d;
    logic signed [D_W+16:0]   w_lgp;
    logic signed [LG_W-1:0]   w_lgt, n_lg, r_lg;
    logic signed [PR_W-1:0]   w_prod, r_prod;
    logic signed [ACC_W-1:0]  w_acc;
    logic [ACC_W-1:0]         w_mag, r_mag;

    assign w_p_s = lead_one(i_signal_power);
    assign w_p_n = lead_one(i_noise_power);

    always_comb begin
        for (int j = 1; j <= F; j++) begin
            w_sq_s[j] = square_step(r_m_s[j-1]);
            w_sq_n[j] = square_step(r_m_n[j-1]);
        end
    end

    assign w_d = ((D_W'($signed({1'b0, r_p_s[F]})) - D_W'($signed({1'b0, r_p_n[F]})))
                  <<< F) + D_W'({1'b0, r_f_s[F]}) - D_W'({1'b0, r_f_n[F]});

    assign w_lgp = (D_W+17)'(r_d) * (D_W+17)'(LOG10_OF_2);
    assign w_lgt = LG_W'(w_lgp);
    assign n_lg  = (r_sz[F+2] || (w_lgt < LG_FLOOR)) ? LG_FLOOR : w_lgt;

    assign w_prod = PR_W'(r_lg) * PR_W'(r_gain);
    assign w_acc  = ACC_W'(r_prod) + (ACC_W'(r_offset) <<< (F + 16));
    assign w_mag  = w_acc[ACC_W-1] ? $unsigned(-w_acc) : $unsigned(w_acc);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_s[0] <= i_signal_power << (5'd31 - w_p_s);
            r_m_n[0] <= i_noise_power << (5'd31 - w_p_n);
            r_p_s[0] <= w_p_s;
            r_p_n[0] <= w_p_n;
            r_f_s[0] <= '0;
            r_f_n[0] <= '0;
            r_nz[1]  <= (i_noise_power == '0);
            r_sz[1]  <= (i_signal_power == '0);
            for (int j = 1; j <= F; j++) begin
                r_m_s[j] <= w_sq_s[j].mant;
                r_m_n[j] <= w_sq_n[j].mant;
                r_p_s[j] <= r_p_s[j-1];
                r_p_n[j] <= r_p_n[j-1];
                r_f_s[j] <= {r_f_s[j-1][F-2:0], w_sq_s[j].bit_out};
                r_f_n[j] <= {r_f_n[j-1][F-2:0], w_sq_n[j].bit_out};
            end
            for (int k = 2; k <= NS; k++) begin
                r_nz[k] <= r_nz[k-1];
            end
            for (int k = 2; k <= F + 2; k++) begin
                r_sz[k] <= r_sz[k-1];
            end
            r_d    <= w_d;
            r_lg   <= n_lg;
            r_prod <= w_prod;
            r_mag  <= w_mag;
        end
    end

    // rounding and saturation
    logic [ACC_W:0]  w_rnd;
    logic [Q_W-1:0]  w_q;
    logic            w_sat;
    logic [15:0]     w_db;

    assign w_rnd = {1'b0, r_mag} + RND_HALF;
    assign w_q   = w_rnd[ACC_W:F+16];
    assign w_sat = r_nz[NS] || (w_q[Q_W-1:16] != '0);
    assign w_db  = w_sat ? 16'hFFFF : w_q[15:0];

    // output register with skid entry
    logic        r_ov;
    logic [15:0] r_odb, r_skid_db;
    logic        r_osat, r_skid_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            if (!r_ov || !i_stall) begin
                r_ov <= r_v[NS];
            end else if (r_v[NS]) begin
                r_skid_v <= 1'b1;
            end
        end else if (!i_stall) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_ov || !i_stall) begin
                r_odb  <= w_db;
                r_osat <= w_sat;
            end else begin
                r_skid_db  <= w_db;
                r_skid_sat <= w_sat;
            end
        end else if (!i_stall) begin
            r_odb  <= r_skid_db;
            r_osat <= r_skid_sat;
        end
    end

    assign o_valid     = r_ov;
    assign o_decibels  = r_odb;
    assign o_saturated = r_osat;

endmodule

### rtl/pwrdb_checker.sv
module pwrdb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_decibels,
    input logic        o_saturated,
    input logic        o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_decibels) && $stable(o_saturated))
        else $error("stalled result changed");

    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_decibels == 16'hFFFF)
        else $error("saturated result without full-scale code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port refused a write");

    a_stall_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !i_stall |=> !o_stall)
        else $error("input stall held after output drained");

endmodule

bind power_ratio_to_decibels pwrdb_checker u_pwrdb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_decibels  (o_decibels),
    .o_saturated (o_saturated),
    .o_cfg_ready (o_cfg_ready)
);

### sim/testbench.sv
`timescale 1ns / 100ps

class decibel_scoreboard;

    localparam int         FRAC_BITS   = pwrdb_pkg::LOG_FRACTION_BITS;
    localparam longint     LOG10_2_Q16 = 19728;
    localparam longint     LOG10_FLOOR = 18;
    localparam logic [15:0] DB_SAT     = 16'hFFFF;
    localparam int         MAX_REPORTS = 10;

    typedef struct packed {
        logic [31:0] signal_power;
        logic [31:0] noise_power;
        logic [15:0] decibels;
        logic        saturated;
    } t_db_result;

    t_db_result  db_due[$];
    logic [15:0] gain_q8_8;
    logic [15:0] offset_q8_8;
    int          n_checked;
    int          n_saturated;
    int          n_mismatch;
    int          n_orphan;

    function new();
        gain_q8_8   = pwrdb_pkg::GAIN_RESET;
        offset_q8_8 = pwrdb_pkg::OFFSET_RESET;
        n_checked   = 0;
        n_saturated = 0;
        n_mismatch  = 0;
        n_orphan    = 0;
    endfunction

    function void set_reg(pwrdb_pkg::t_cfg_idx idx, logic [15:0] data);
        case (idx)
            pwrdb_pkg::CFG_GAIN:   gain_q8_8   = data;
            pwrdb_pkg::CFG_OFFSET: offset_q8_8 = data;
            default: ;
        endcase
    endfunction

    // log2 of a nonzero Q16.16 value, in units of 2^-FRAC_BITS, truncated
    function longint log2_fixed(logic [31:0] x);
        int          msb;
        logic [31:0] m;
        logic [63:0] sq;
        longint      frac;
        msb = 0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                msb = i;
            end
        end
        m = x << (31 - msb);
        frac = 0;
        for (int k = 0; k < FRAC_BITS; k++) begin
            sq = {32'd0, m} * {32'd0, m};
            frac = frac * 2;
            if (sq[63]) begin
                frac = frac + 1;
                m = sq[63:32];
            end else begin
                m = sq[62:31];
            end
        end
        return longint'(msb - 16) * (longint'(1) << FRAC_BITS) + frac;
    endfunction

    function t_db_result ratio_to_db(logic [31:0] s, logic [31:0] n);
        longint      unit;
        longint      lg;
        longint      acc;
        logic [63:0] mag;
        t_db_result  r;
        unit = longint'(1) << (FRAC_BITS + 16);
        r.signal_power = s;
        r.noise_power  = n;
        if (n == 32'd0) begin
            r.decibels  = DB_SAT;
            r.saturated = 1'b1;
            return r;
        end
        if (s == 32'd0) begin
            lg = -LOG10_FLOOR * unit;
        end else begin
            lg = (log2_fixed(s) - log2_fixed(n)) * LOG10_2_Q16;
            if (lg < -LOG10_FLOOR * unit) begin
                lg = -LOG10_FLOOR * unit;
            end
        end
        acc = lg * longint'($signed(gain_q8_8)) + longint'($signed(offset_q8_8)) * unit;
        mag = (acc < 0) ? 64'(-acc) : 64'(acc);
        mag = (mag + (64'd1 << (FRAC_BITS + 15))) >> (FRAC_BITS + 16);
        if (mag > 64'd65535) begin
            r.decibels  = DB_SAT;
            r.saturated = 1'b1;
        end else begin
            r.decibels  = mag[15:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    function void note_input(logic [31:0] s, logic [31:0] n);
        db_due.push_back(ratio_to_db(s, n));
    endfunction

    function void check_result(logic [15:0] decibels, logic saturated);
        t_db_result exp_r;
        if (db_due.size() == 0) begin
            n_orphan++;
            if (n_mismatch + n_orphan <= MAX_REPORTS) begin
                $display("unexpected result: db=%h sat=%b", decibels, saturated);
            end
            return;
        end
        exp_r = db_due.pop_front();
        n_checked++;
        if (saturated) begin
            n_saturated++;
        end
        if (decibels !== exp_r.decibels || saturated !== exp_r.saturated) begin
            n_mismatch++;
            if (n_mismatch + n_orphan <= MAX_REPORTS) begin
                $display("mismatch: S=%h N=%h gain=%h offset=%h exp db=%h sat=%b, got db=%h sat=%b",
                         exp_r.signal_power, exp_r.noise_power, gain_q8_8, offset_q8_8,
                         exp_r.decibels, exp_r.saturated, decibels, saturated);
            end
        end
    endfunction

    function int pending();
        return db_due.size();
    endfunction

    function int total_failures();
        return n_mismatch + n_orphan + db_due.size();
    endfunction

endclass

module testbench;

    localparam int LATENCY      = pwrdb_pkg::LOG_FRACTION_BITS + 6;
    localparam int SETTLE       = LATENCY + 6;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 170;
    localparam int N_SETTINGS   = 9;
    localparam int N_DIRECTED   = 22;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_signal_power = '0;
    logic [31:0] i_noise_power = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_decibels;
    logic        o_saturated;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    decibel_scoreboard sb;
    int            quiet_cycles = 0;
    int            burst_left = 0;
    int            n_sent = 0;
    int            n_settings = 0;
    t_stall_mode   stall_mode = STALL_NONE;
    int            stall_left = 0;
    int            stall_phase = 0;

    logic [31:0] dir_signal [N_DIRECTED] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000,
        32'h0001_0000, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678,
        32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0001, 32'h0000_0003, 32'h0000_0000,
        32'h0064_0000, 32'h0000_FFFF
    };
    logic [31:0] dir_noise [N_DIRECTED] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000,
        32'h0000_0001, 32'h0001_0000, 32'h0000_0001, 32'h8000_0000, 32'h9ABC_DEF0,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000, 32'h0000_0002, 32'h0001_2345,
        32'h0000_0001, 32'h0001_0000
    };

    logic [15:0] set_gain   [N_SETTINGS];
    logic [15:0] set_offset [N_SETTINGS];

    power_ratio_to_decibels DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_signal_power (i_signal_power),
        .i_noise_power  (i_noise_power),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_decibels     (o_decibels),
        .o_saturated    (o_saturated),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_decibels, o_saturated);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_SPARSE:   i_stall <= ($urandom_range(0, 99) < 25);
            STALL_PERIODIC: i_stall <= ((stall_phase % 7) < 3);
            STALL_HEAVY:    i_stall <= ($urandom_range(0, 99) < 75);
            default:        i_stall <= 1'b0;
        endcase
    end

    function automatic int next_burst_len();
        if ($urandom_range(0, 99) < 20) begin
            return $urandom_range(40, 150);
        end
        return $urandom_range(1, 12);
    endfunction

    function automatic logic [31:0] pick_power();
        int          r;
        logic [31:0] corner [5] = '{32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1_0000,
                                   32'h7FFF_FFFF};
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return 32'd0;
        end else if (r < 12) begin
            return corner[$urandom_range(0, 4)];
        end else if (r < 45) begin
            return $urandom >> $urandom_range(0, 31);
        end
        return $urandom;
    endfunction

    // called at a rising edge; returns at the edge where the item was taken, or after the idle gap when a burst ends
    task automatic send_power_pair(logic [31:0] s, logic [31:0] n);
        i_valid        <= 1'b1;
        i_signal_power <= s;
        i_noise_power  <= n;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(s, n);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = next_burst_len();
        end
    endtask

    task automatic send_random_items(int count);
        logic [31:0] s;
        logic [31:0] n;
        for (int k = 0; k < count; k++) begin
            s = pick_power();
            if ($urandom_range(0, 99) < 15) begin
                n = s + $urandom_range(0, 3) - 1;
            end else begin
                n = pick_power();
            end
            send_power_pair(s, n);
        end
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_settings(logic [15:0] gain, logic [15:0] offset);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= pwrdb_pkg::CFG_GAIN;
        i_cfg_data  <= gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(pwrdb_pkg::CFG_GAIN, gain);
        i_cfg_index <= pwrdb_pkg::CFG_OFFSET;
        i_cfg_data  <= offset;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(pwrdb_pkg::CFG_OFFSET, offset);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("no handshake for %0d cycles", QUIET_LIMIT);
        $display("** power_ratio_to_decibels: FAILED **");
        $finish;
    end

    initial begin
        sb = new();
        set_gain   = '{16'h7FFF, 16'h8000, 16'h0000, 16'd2560, -16'sd2560, 16'h0001,
                       16'hFFFF, 16'h0000, 16'h0000};
        set_offset = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'd1280, 16'hFFFF,
                       16'h0001, 16'h0000, 16'h0000};
        set_gain[7]   = 16'($urandom);
        set_offset[7] = 16'($urandom);
        set_gain[8]   = 16'($urandom_range(0, 8191) - 4096);
        set_offset[8] = 16'($urandom_range(0, 16383) - 8192);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = next_burst_len();

        // reset register values first
        for (int k = 0; k < N_DIRECTED; k++) begin
            send_power_pair(dir_signal[k], dir_noise[k]);
        end
        send_random_items(PHASE_ITEMS - N_DIRECTED);

        for (int p = 0; p < N_SETTINGS; p++) begin
            drain_pipeline();
            load_settings(set_gain[p], set_offset[p]);
            send_random_items(PHASE_ITEMS);
        end
        drain_pipeline();

        $display("sent %0d items under %0d register settings (reset values included)",
                 n_sent, n_settings + 1);
        $display("checked %0d results, %0d saturated, %0d failures",
                 sb.n_checked, sb.n_saturated, sb.total_failures());
        if (sb.total_failures() == 0) begin
            $display("** power_ratio_to_decibels: PASSED **");
        end else begin
            $display("** power_ratio_to_decibels: FAILED **");
        end
        $finish;
    end

endmodule

### power_ratio_to_decibels.f
rtl/pwrdb_pkg.sv
rtl/power_ratio_to_decibels.sv
rtl/pwrdb_checker.sv
sim/testbench.sv
